>>> rtl/apsf_pkg.sv
// ----------------------------------------------------------------------------
// apsf_pkg
// Shared widths, register codes and reset values for the anisotropic
// piecewise spring force block.
// ----------------------------------------------------------------------------
package apsf_pkg;

  localparam int STRAIN_W   = 18;
  localparam int COS_W      = 17;
  localparam int SCALE_W    = 24;
  localparam int FORCE_W    = 49;
  localparam int SLOPE_W    = 22;
  localparam int KNEE_W     = 16;
  localparam int STIFF_W    = 24;
  localparam int SQ_W       = 2 * STIFF_W;
  localparam int BLEND_W    = 64;
  localparam int ROOT_W     = 32;
  localparam int CFG_W      = 22;
  localparam int CFG_IDX_W  = 3;

  localparam int STRAIN_FRAC_BITS_DEF = 16;

  localparam logic [COS_W-1:0] COS_ONE = 17'd65536;

  localparam logic [SLOPE_W-1:0] SLOPE_FIRST_RST  = 22'd106000;
  localparam logic [SLOPE_W-1:0] SLOPE_SECOND_RST = 22'd569000;
  localparam logic [SLOPE_W-1:0] SLOPE_THIRD_RST  = 22'd1200000;
  localparam logic [KNEE_W-1:0]  KNEE_FIRST_RST   = 16'd9830;
  localparam logic [KNEE_W-1:0]  KNEE_SECOND_RST  = 16'd19661;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_FIRST   = 3'd0,
    REG_LONG_SECOND  = 3'd1,
    REG_LONG_THIRD   = 3'd2,
    REG_CROSS_FIRST  = 3'd3,
    REG_CROSS_SECOND = 3'd4,
    REG_CROSS_THIRD  = 3'd5,
    REG_KNEE_FIRST   = 3'd6,
    REG_KNEE_SECOND  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_LOW  = 2'd0,
    SEG_MID  = 2'd1,
    SEG_HIGH = 2'd2
  } seg_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] first;
    logic [SLOPE_W-1:0] second;
    logic [SLOPE_W-1:0] third;
  } slopes_t;

  typedef struct packed {
    logic [KNEE_W-1:0] first;
    logic [KNEE_W-1:0] second;
  } knees_t;

endpackage

>>> rtl/anisotropic_piecewise_spring_force.sv
// ----------------------------------------------------------------------------
// anisotropic_piecewise_spring_force
// Per-spring force from strain, fiber angle and scale, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_strain, in_cos_sq, in_scale) move on in_valid/in_stall,
//   results (out_spring_force) on out_valid/out_stall. Each item gives
//   exactly one result, in order.
//   One item is taken every cycle while in_stall is low. The depth is set
//   by the square root, one bit per stage (32 stages), plus the stiffness
//   curves, squaring, blend and scaling.
//   A stall on the output holds only the stages that hold valid items, so
//   empty stages keep filling; in_stall rises once every stage up to the
//   input is full. Nothing is dropped or repeated.
//   The cfg port writes one register per clock with cfg_wr_en; write it only
//   while no item is in flight.
//   Synchronous reset (rst_n low) empties the pipeline and loads the default
//   slopes and knees.
// ----------------------------------------------------------------------------
module anisotropic_piecewise_spring_force #(
  parameter int STRAIN_FRAC_BITS = apsf_pkg::STRAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [apsf_pkg::STRAIN_W-1:0] in_strain,
  input  logic [apsf_pkg::COS_W-1:0]           in_cos_sq,
  input  logic [apsf_pkg::SCALE_W-1:0]         in_scale,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [apsf_pkg::FORCE_W-1:0]  out_spring_force,
  input  logic                                 cfg_wr_en,
  input  logic [apsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apsf_pkg::CFG_W-1:0]           cfg_wdata
);
  import apsf_pkg::*;

  // stage map: 0 input, 1..3 curves, 4 square, 5 weight, 6 blend,
  // 7..38 root, 39 scale product, 40 output
  localparam int ST_CURVE = 1;
  localparam int ST_SQ    = 4;
  localparam int ST_WGT   = 5;
  localparam int ST_BLEND = 6;
  localparam int ST_ROOT  = 7;
  localparam int ST_MUL   = ST_ROOT + ROOT_W;
  localparam int ST_OUT   = ST_MUL + 1;
  localparam int NST      = ST_OUT + 1;
  localparam int SB_N     = ST_MUL - ST_CURVE;
  localparam int PROD_W   = ROOT_W + SCALE_W;

  // configuration
  slopes_t long_r, cross_r;
  knees_t  knees_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r  <= '{SLOPE_FIRST_RST, SLOPE_SECOND_RST, SLOPE_THIRD_RST};
      cross_r <= '{SLOPE_FIRST_RST, SLOPE_SECOND_RST, SLOPE_THIRD_RST};
      knees_r <= '{KNEE_FIRST_RST, KNEE_SECOND_RST};
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LONG_FIRST:   long_r.first   <= cfg_wdata[SLOPE_W-1:0];
        REG_LONG_SECOND:  long_r.second  <= cfg_wdata[SLOPE_W-1:0];
        REG_LONG_THIRD:   long_r.third   <= cfg_wdata[SLOPE_W-1:0];
        REG_CROSS_FIRST:  cross_r.first  <= cfg_wdata[SLOPE_W-1:0];
        REG_CROSS_SECOND: cross_r.second <= cfg_wdata[SLOPE_W-1:0];
        REG_CROSS_THIRD:  cross_r.third  <= cfg_wdata[SLOPE_W-1:0];
        REG_KNEE_FIRST:   knees_r.first  <= cfg_wdata[KNEE_W-1:0];
        REG_KNEE_SECOND:  knees_r.second <= cfg_wdata[KNEE_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage hold: a stage holds only if it is full and
  // the stage after it holds
  logic [NST-1:0] vld_r;
  logic [NST-1:0] hold;
  logic [NST-1:0] ld;

  always_comb begin
    hold[NST-1] = vld_r[NST-1] & out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      hold[i] = vld_r[i] & hold[i+1];
    end
    ld = ~hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = vld_r[NST-1];

  // stage 0: magnitude, sign, clamped cosine
  logic [STRAIN_W-1:0] mag_r;
  logic                neg_r;
  logic [COS_W-1:0]    cos_r;
  logic [SCALE_W-1:0]  scale_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      neg_r   <= in_strain[STRAIN_W-1];
      mag_r   <= in_strain[STRAIN_W-1] ? STRAIN_W'(-in_strain) : STRAIN_W'(in_strain);
      cos_r   <= (in_cos_sq > COS_ONE) ? COS_ONE : in_cos_sq;
      scale_r <= in_scale;
    end
  end

  // sidebands from stage 1 through the last root stage
  logic               neg_sb_r   [SB_N];
  logic [COS_W-1:0]   cos_sb_r   [SB_N];
  logic [SCALE_W-1:0] scale_sb_r [SB_N];

  always_ff @(posedge clk) begin
    if (ld[ST_CURVE]) begin
      neg_sb_r[0]   <= neg_r;
      cos_sb_r[0]   <= cos_r;
      scale_sb_r[0] <= scale_r;
    end
    for (int i = 1; i < SB_N; i++) begin
      if (ld[ST_CURVE+i]) begin
        neg_sb_r[i]   <= neg_sb_r[i-1];
        cos_sb_r[i]   <= cos_sb_r[i-1];
        scale_sb_r[i] <= scale_sb_r[i-1];
      end
    end
  end

  // stages 1..3: both stiffness curves
  logic [STIFF_W-1:0] m1, m2;

  apsf_curve #(.STRAIN_FRAC_BITS(STRAIN_FRAC_BITS)) u_long (
    .clk    (clk),
    .ld     (ld[ST_CURVE +: 3]),
    .mag    (mag_r),
    .slopes (long_r),
    .knees  (knees_r),
    .stiff  (m1)
  );

  apsf_curve #(.STRAIN_FRAC_BITS(STRAIN_FRAC_BITS)) u_cross (
    .clk    (clk),
    .ld     (ld[ST_CURVE +: 3]),
    .mag    (mag_r),
    .slopes (cross_r),
    .knees  (knees_r),
    .stiff  (m2)
  );

  // stage 4: squares
  logic [SQ_W-1:0] m1sq_r, m2sq_r;
  always_ff @(posedge clk) begin
    if (ld[ST_SQ]) begin
      m1sq_r <= m1 * m1;
      m2sq_r <= m2 * m2;
    end
  end

  // stage 5: weighting by cos^2 and its complement
  localparam int W_W = SQ_W + COS_W;
  logic [COS_W-1:0]   cos_w;
  logic [W_W-1:0]     w1, w2;
  logic [BLEND_W-1:0] t1_r, t2_r;

  always_comb begin
    cos_w = cos_sb_r[ST_WGT-ST_CURVE-1];
    w1    = m1sq_r * cos_w;
    w2    = m2sq_r * (COS_ONE - cos_w);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_WGT]) begin
      t1_r <= w1[BLEND_W-1:0];
      t2_r <= w2[BLEND_W-1:0];
    end
  end

  // stage 6: blend sum, fits 64 bits since the weights sum to one
  logic [BLEND_W-1:0] blend_r;
  always_ff @(posedge clk) begin
    if (ld[ST_BLEND]) begin
      blend_r <= t1_r + t2_r;
    end
  end

  // stages 7..38: floor square root
  logic [ROOT_W-1:0] root;
  apsf_sqrt u_sqrt (
    .clk      (clk),
    .ld       (ld[ST_ROOT +: ROOT_W]),
    .radicand (blend_r),
    .root     (root)
  );

  // stage 39: scale product
  logic [PROD_W-1:0] prod_r;
  logic              neg_m_r;
  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      prod_r  <= root * scale_sb_r[SB_N-1];
      neg_m_r <= neg_sb_r[SB_N-1];
    end
  end

  // stage 40: round, drop 8 bits, apply sign
  logic [PROD_W:0]     rnd;
  logic [FORCE_W-1:0]  fmag;
  logic [FORCE_W-1:0]  force_r;

  always_comb begin
    rnd  = {1'b0, prod_r} + (PROD_W + 1)'(128);
    fmag = {1'b0, rnd[PROD_W-1:8]};
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      force_r <= neg_m_r ? (~fmag + FORCE_W'(1)) : fmag;
    end
  end

  assign out_spring_force = force_r;

endmodule

>>> rtl/apsf_curve.sv
// ----------------------------------------------------------------------------
// apsf_curve
// Three-stage piecewise-linear stiffness curve: segment pick, products,
// sum with half-up rounding and saturation to 24 bits.
// ----------------------------------------------------------------------------
module apsf_curve #(
  parameter int STRAIN_FRAC_BITS = apsf_pkg::STRAIN_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic [2:0]                    ld,
  input  logic [apsf_pkg::STRAIN_W-1:0] mag,
  input  apsf_pkg::slopes_t             slopes,
  input  apsf_pkg::knees_t              knees,
  output logic [apsf_pkg::STIFF_W-1:0]  stiff
);
  import apsf_pkg::*;

  localparam int PROD_W = SLOPE_W + KNEE_W;
  localparam int Q_W    = SLOPE_W + STRAIN_W;
  localparam int BASE_W = PROD_W + 1;
  localparam int ACC_W  = Q_W + 2;

  logic [KNEE_W-1:0]   k2e;
  seg_t                seg_nxt;
  logic [STRAIN_W-1:0] d_nxt;
  logic [SLOPE_W-1:0]  ssel_nxt;

  seg_t                seg_r;
  logic [STRAIN_W-1:0] d_r;
  logic [SLOPE_W-1:0]  ssel_r;
  logic [PROD_W-1:0]   p1_r, p2_r;
  logic [Q_W-1:0]      q_r;
  logic [BASE_W-1:0]   base_nxt, base_r;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    shr;
  logic [STIFF_W-1:0]  stiff_r;

  always_comb begin
    k2e = (knees.second < knees.first) ? knees.first : knees.second;
    if (mag < {2'b00, knees.first}) begin
      seg_nxt  = SEG_LOW;
      d_nxt    = mag;
      ssel_nxt = slopes.first;
    end else if (mag < {2'b00, k2e}) begin
      seg_nxt  = SEG_MID;
      d_nxt    = mag - {2'b00, knees.first};
      ssel_nxt = slopes.second;
    end else begin
      seg_nxt  = SEG_HIGH;
      d_nxt    = mag - {2'b00, k2e};
      ssel_nxt = slopes.third;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      seg_r  <= seg_nxt;
      d_r    <= d_nxt;
      ssel_r <= ssel_nxt;
      p1_r   <= slopes.first * knees.first;
      p2_r   <= slopes.second * (k2e - knees.first);
    end
  end

  always_comb begin
    unique case (seg_r)
      SEG_LOW:  base_nxt = '0;
      SEG_MID:  base_nxt = {1'b0, p1_r};
      SEG_HIGH: base_nxt = {1'b0, p1_r} + {1'b0, p2_r};
      default:  base_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      q_r    <= ssel_r * d_r;
      base_r <= base_nxt;
    end
  end

  // round half up at the strain fraction point, then clip
  always_comb begin
    acc = {{(ACC_W-BASE_W){1'b0}}, base_r} + {2'b00, q_r}
        + (ACC_W'(1) << (STRAIN_FRAC_BITS - 1));
    shr = acc >> STRAIN_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      stiff_r <= (|shr[ACC_W-1:STIFF_W]) ? {STIFF_W{1'b1}} : shr[STIFF_W-1:0];
    end
  end

  assign stiff = stiff_r;

endmodule

>>> rtl/apsf_sqrt.sv
// ----------------------------------------------------------------------------
// apsf_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module apsf_sqrt (
  input  logic                         clk,
  input  logic [apsf_pkg::ROOT_W-1:0]  ld,
  input  logic [apsf_pkg::BLEND_W-1:0] radicand,
  output logic [apsf_pkg::ROOT_W-1:0]  root
);
  import apsf_pkg::*;

  logic [BLEND_W-1:0] rem_r [ROOT_W];
  logic [BLEND_W-1:0] res_r [ROOT_W];

  genvar j;
  generate
    for (j = 0; j < ROOT_W; j++) begin : g_stage
      localparam logic [BLEND_W-1:0] BIT = BLEND_W'(1) << (2 * (ROOT_W - 1 - j));
      logic [BLEND_W-1:0] rem_in, res_in, trial;
      if (j == 0) begin : g_first
        assign rem_in = radicand;
        assign res_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[j-1];
        assign res_in = res_r[j-1];
      end
      assign trial = res_in + BIT;
      always_ff @(posedge clk) begin
        if (ld[j]) begin
          if (rem_in >= trial) begin
            rem_r[j] <= rem_in - trial;
            res_r[j] <= (res_in >> 1) + BIT;
          end else begin
            rem_r[j] <= rem_in;
            res_r[j] <= res_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign root = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule
